### rtl/lcdseq_pkg.sv
package lcdseq_pkg;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_INSTR = 3'd1;
  localparam logic [2:0] CMD_DATA  = 3'd2;
  localparam logic [2:0] CMD_GOTO  = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;

  localparam int ROM_DEPTH = 29;
  localparam int PC_W      = $clog2(ROM_DEPTH);

  localparam logic [PC_W-1:0] ENTRY_INIT  = PC_W'(0);
  localparam logic [PC_W-1:0] ENTRY_CLEAR = PC_W'(21);
  localparam logic [PC_W-1:0] ENTRY_BYTE  = PC_W'(25);
  localparam logic [PC_W-1:0] ROM_LAST    = PC_W'(ROM_DEPTH - 1);

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] value;
    logic [5:0] column;
    logic       row;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic       enable;
    logic [3:0] nibble;
    logic [5:0] hold_ms;
    logic       last;
  } seg_t;

  typedef enum logic [1:0] {
    SEL_CONST = 2'b00,
    SEL_HI    = 2'b01,
    SEL_LO    = 2'b10
  } nib_sel_t;

  typedef struct packed {
    nib_sel_t   sel;
    logic [3:0] nib;
    logic       en;
    logic [5:0] hold;
    logic       last;
  } ucode_t;

  typedef struct packed {
    logic   fire;
    ucode_t word;
  } step_t;

  // Control store. Init runs from the start and falls through into the clear
  // sequence; byte requests use the four-step routine at the end.
  function automatic ucode_t rom_word(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{SEL_CONST, 4'h0, 1'b0, 6'd1, 1'b1};
    case (pc)
      5'd0:  w = '{SEL_CONST, 4'h0, 1'b0, 6'd40, 1'b0};
      5'd1:  w = '{SEL_CONST, 4'h3, 1'b1, 6'd1, 1'b0};
      5'd2:  w = '{SEL_CONST, 4'h3, 1'b0, 6'd6, 1'b0};
      5'd3:  w = '{SEL_CONST, 4'h3, 1'b1, 6'd1, 1'b0};
      5'd4:  w = '{SEL_CONST, 4'h3, 1'b0, 6'd2, 1'b0};
      5'd5:  w = '{SEL_CONST, 4'h3, 1'b1, 6'd1, 1'b0};
      5'd6:  w = '{SEL_CONST, 4'h3, 1'b0, 6'd2, 1'b0};
      5'd7:  w = '{SEL_CONST, 4'h2, 1'b1, 6'd1, 1'b0};
      5'd8:  w = '{SEL_CONST, 4'h2, 1'b0, 6'd1, 1'b0};
      5'd9:  w = '{SEL_CONST, 4'h2, 1'b1, 6'd1, 1'b0};
      5'd10: w = '{SEL_CONST, 4'h2, 1'b0, 6'd1, 1'b0};
      5'd11: w = '{SEL_CONST, 4'h8, 1'b1, 6'd1, 1'b0};
      5'd12: w = '{SEL_CONST, 4'h8, 1'b0, 6'd3, 1'b0};
      5'd13: w = '{SEL_CONST, 4'h0, 1'b1, 6'd1, 1'b0};
      5'd14: w = '{SEL_CONST, 4'h0, 1'b0, 6'd1, 1'b0};
      5'd15: w = '{SEL_CONST, 4'hC, 1'b1, 6'd1, 1'b0};
      5'd16: w = '{SEL_CONST, 4'hC, 1'b0, 6'd3, 1'b0};
      5'd17: w = '{SEL_CONST, 4'h0, 1'b1, 6'd1, 1'b0};
      5'd18: w = '{SEL_CONST, 4'h0, 1'b0, 6'd1, 1'b0};
      5'd19: w = '{SEL_CONST, 4'h6, 1'b1, 6'd1, 1'b0};
      5'd20: w = '{SEL_CONST, 4'h6, 1'b0, 6'd3, 1'b0};
      5'd21: w = '{SEL_CONST, 4'h0, 1'b1, 6'd1, 1'b0};
      5'd22: w = '{SEL_CONST, 4'h0, 1'b0, 6'd1, 1'b0};
      5'd23: w = '{SEL_CONST, 4'h1, 1'b1, 6'd1, 1'b0};
      5'd24: w = '{SEL_CONST, 4'h1, 1'b0, 6'd5, 1'b1};
      5'd25: w = '{SEL_HI,    4'h0, 1'b1, 6'd1, 1'b0};
      5'd26: w = '{SEL_HI,    4'h0, 1'b0, 6'd1, 1'b0};
      5'd27: w = '{SEL_LO,    4'h0, 1'b1, 6'd1, 1'b0};
      5'd28: w = '{SEL_LO,    4'h0, 1'b0, 6'd3, 1'b1};
      default: w = '{SEL_CONST, 4'h0, 1'b0, 6'd1, 1'b1};
    endcase
    return w;
  endfunction

endpackage

### rtl/char_lcd_nibble_sequencer.sv
// A taken request loads its entry step; each step fires into the output register.
// One segment per cycle from the control store while the output is not stalled;
// an unknown command starts no sequence and issues no segments.
// The next request is taken in the cycle that issues the final step of the current one.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
module char_lcd_nibble_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  lcdseq_pkg::req_t  req,
  output logic              seg_valid,
  input  logic              seg_stall,
  output lcdseq_pkg::seg_t  seg
);

  logic              accept;
  logic              adv_ok;
  lcdseq_pkg::step_t step;

  assign accept = req_valid && !req_stall;
  assign adv_ok = !seg_valid || !seg_stall;

  lcdseq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (req.cmd),
    .adv_ok (adv_ok),
    .stall  (req_stall),
    .step   (step)
  );

  lcdseq_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .step      (step),
    .seg_stall (seg_stall),
    .seg_valid (seg_valid),
    .seg       (seg)
  );

endmodule

### rtl/lcdseq_ctrl.sv
module lcdseq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [2:0]         cmd,
  input  logic               adv_ok,
  output logic               stall,
  output lcdseq_pkg::step_t  step
);

  logic                         busy;
  logic [lcdseq_pkg::PC_W-1:0] pc;
  logic [lcdseq_pkg::PC_W-1:0] entry;
  logic                         cmd_known;
  lcdseq_pkg::ucode_t           word;

  assign word      = lcdseq_pkg::rom_word(pc);
  assign step.fire = busy && adv_ok;
  assign step.word = word;
  assign stall     = busy && !(step.fire && word.last);

  always_comb begin
    entry     = lcdseq_pkg::ENTRY_INIT;
    cmd_known = 1'b1;
    case (cmd)
      lcdseq_pkg::CMD_INIT:  entry = lcdseq_pkg::ENTRY_INIT;
      lcdseq_pkg::CMD_INSTR: entry = lcdseq_pkg::ENTRY_BYTE;
      lcdseq_pkg::CMD_DATA:  entry = lcdseq_pkg::ENTRY_BYTE;
      lcdseq_pkg::CMD_GOTO:  entry = lcdseq_pkg::ENTRY_BYTE;
      lcdseq_pkg::CMD_CLEAR: entry = lcdseq_pkg::ENTRY_CLEAR;
      default: cmd_known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= lcdseq_pkg::ENTRY_INIT;
    end else if (accept) begin
      busy <= cmd_known;
      pc   <= entry;
    end else if (step.fire) begin
      if (word.last) begin
        busy <= 1'b0;
      end else begin
        pc <= pc + 1'b1;
      end
    end
  end

  a_pc_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= lcdseq_pkg::ROM_LAST)
    else $error("Step counter ran beyond the control store.");

  a_start_entry: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_known |=> busy && (pc == lcdseq_pkg::ENTRY_INIT ||
      pc == lcdseq_pkg::ENTRY_CLEAR || pc == lcdseq_pkg::ENTRY_BYTE))
    else $error("A known command did not start at an entry point.");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    step.fire && !word.last && !accept |=> busy && pc == $past(pc) + 1'b1)
    else $error("Sequence stopped before its final step.");

endmodule

### rtl/lcdseq_datapath.sv
module lcdseq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  lcdseq_pkg::req_t   req,
  input  lcdseq_pkg::step_t  step,
  input  logic               seg_stall,
  output logic               seg_valid,
  output lcdseq_pkg::seg_t   seg
);

  logic             rs_sel;
  logic [7:0]       data_byte;
  lcdseq_pkg::seg_t seg_next;

  always_comb begin
    seg_next.reg_select = rs_sel;
    seg_next.enable     = step.word.en;
    seg_next.hold_ms    = step.word.hold;
    seg_next.last       = step.word.last;
    case (step.word.sel)
      lcdseq_pkg::SEL_CONST: seg_next.nibble = step.word.nib;
      lcdseq_pkg::SEL_HI:    seg_next.nibble = data_byte[7:4];
      lcdseq_pkg::SEL_LO:    seg_next.nibble = data_byte[3:0];
      default:               seg_next.nibble = step.word.nib;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rs_sel <= (req.cmd == lcdseq_pkg::CMD_DATA);
      if (req.cmd == lcdseq_pkg::CMD_GOTO) begin
        data_byte <= {1'b1, req.row, req.column};
      end else begin
        data_byte <= req.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (step.fire) begin
      seg_valid <= 1'b1;
    end else if (!seg_stall) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.fire) begin
      seg <= seg_next;
    end
  end

endmodule

### tb/tb.sv
module tb;

  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam logic [7:0] FUNC_SET   = 8'h28;
  localparam logic [7:0] DISP_ON    = 8'h0C;
  localparam logic [7:0] ENTRY_MODE = 8'h06;
  localparam logic [7:0] CLEAR_DISP = 8'h01;
  localparam logic [7:0] SET_DDRAM  = 8'h80;
  localparam logic [7:0] LINE_TWO   = 8'h40;
  localparam logic [3:0] WAKE_NIB   = 4'h3;
  localparam logic [3:0] BUS4_NIB   = 4'h2;

  localparam int RANDOM_REQUESTS = 200;
  localparam int STUCK_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 40;

  typedef struct packed {
    lcdseq_pkg::req_t       rq;
    logic                   typed;
    lcdseq_pkg::seg_t [0:3] exp;
  } row_t;

  logic             clk;
  logic             rst;
  logic             req_valid;
  logic             req_stall;
  lcdseq_pkg::req_t req;
  logic             seg_valid;
  logic             seg_stall;
  lcdseq_pkg::seg_t seg;

  lcdseq_pkg::seg_t pending_segs[$];
  row_t             sent_rows[$];
  int               mismatches;
  int               cycle;
  int               stuck_cycles;
  bit               steady;

  // Rows with typed expectations are those whose segments can be read off directly.
  row_t dir_tab [0:17] = '{
    '{'{lcdseq_pkg::CMD_INIT,  8'h00, 6'd0,  1'b0}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_INSTR, 8'hFF, 6'd0,  1'b0}, 1'b1,
      '{'{1'b0, 1'b1, 4'hF, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'hF, 6'd1, 1'b0},
        '{1'b0, 1'b1, 4'hF, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'hF, 6'd3, 1'b1}}},
    '{'{lcdseq_pkg::CMD_INSTR, 8'h00, 6'd63, 1'b1}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_DATA,  8'h00, 6'd0,  1'b0}, 1'b1,
      '{'{1'b1, 1'b1, 4'h0, 6'd1, 1'b0}, '{1'b1, 1'b0, 4'h0, 6'd1, 1'b0},
        '{1'b1, 1'b1, 4'h0, 6'd1, 1'b0}, '{1'b1, 1'b0, 4'h0, 6'd3, 1'b1}}},
    '{'{lcdseq_pkg::CMD_DATA,  8'hFF, 6'd0,  1'b0}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_DATA,  8'hA5, 6'd21, 1'b1}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_GOTO,  8'hFF, 6'd0,  1'b0}, 1'b1,
      '{'{1'b0, 1'b1, 4'h8, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'h8, 6'd1, 1'b0},
        '{1'b0, 1'b1, 4'h0, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'h0, 6'd3, 1'b1}}},
    '{'{lcdseq_pkg::CMD_GOTO,  8'h00, 6'd39, 1'b0}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_GOTO,  8'h00, 6'd39, 1'b1}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_GOTO,  8'h00, 6'd63, 1'b1}, 1'b1,
      '{'{1'b0, 1'b1, 4'hF, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'hF, 6'd1, 1'b0},
        '{1'b0, 1'b1, 4'hF, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'hF, 6'd3, 1'b1}}},
    '{'{lcdseq_pkg::CMD_GOTO,  8'h5A, 6'd0,  1'b1}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_CLEAR, 8'h3C, 6'd42, 1'b1}, 1'b1,
      '{'{1'b0, 1'b1, 4'h0, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'h0, 6'd1, 1'b0},
        '{1'b0, 1'b1, 4'h1, 6'd1, 1'b0}, '{1'b0, 1'b0, 4'h1, 6'd5, 1'b1}}},
    '{'{CMD_RSVD5, 8'hFF, 6'd63, 1'b1}, 1'b0, '0},
    '{'{CMD_RSVD6, 8'h00, 6'd0,  1'b0}, 1'b0, '0},
    '{'{CMD_RSVD7, 8'h5A, 6'd21, 1'b0}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_INIT,  8'hFF, 6'd63, 1'b1}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_INSTR, 8'h5A, 6'd42, 1'b0}, 1'b0, '0},
    '{'{lcdseq_pkg::CMD_DATA,  8'h3C, 6'd5,  1'b1}, 1'b0, '0}
  };

  char_lcd_nibble_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic push_seg(input logic rs, input logic en, input logic [3:0] nib,
                          input logic [5:0] hold);
    lcdseq_pkg::seg_t s;
    s.reg_select = rs;
    s.enable     = en;
    s.nibble     = nib;
    s.hold_ms    = hold;
    s.last       = 1'b0;
    pending_segs.push_back(s);
  endtask

  task automatic push_nibble(input logic rs, input logic [3:0] nib, input logic [5:0] low_hold);
    push_seg(rs, 1'b1, nib, 6'd1);
    push_seg(rs, 1'b0, nib, low_hold);
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [5:0] extra);
    push_nibble(rs, b[7:4], 6'd1);
    push_nibble(rs, b[3:0], 6'd1 + extra);
  endtask

  task automatic predict_segments(input lcdseq_pkg::req_t r);
    int               n0;
    lcdseq_pkg::seg_t s;
    n0 = pending_segs.size();
    case (r.cmd)
      lcdseq_pkg::CMD_INIT: begin
        push_seg(1'b0, 1'b0, 4'h0, 6'd40);
        push_nibble(1'b0, WAKE_NIB, 6'd6);
        push_nibble(1'b0, WAKE_NIB, 6'd2);
        push_nibble(1'b0, WAKE_NIB, 6'd2);
        push_nibble(1'b0, BUS4_NIB, 6'd1);
        push_byte(1'b0, FUNC_SET, 6'd2);
        push_byte(1'b0, DISP_ON, 6'd2);
        push_byte(1'b0, ENTRY_MODE, 6'd2);
        push_byte(1'b0, CLEAR_DISP, 6'd4);
      end
      lcdseq_pkg::CMD_INSTR: push_byte(1'b0, r.value, 6'd2);
      lcdseq_pkg::CMD_DATA:  push_byte(1'b1, r.value, 6'd2);
      lcdseq_pkg::CMD_GOTO: begin
        push_byte(1'b0, SET_DDRAM | (r.row ? LINE_TWO : 8'h00) + {2'b00, r.column},
                  6'd2);
      end
      lcdseq_pkg::CMD_CLEAR: push_byte(1'b0, CLEAR_DISP, 6'd4);
      default: ;
    endcase
    if (pending_segs.size() > n0) begin
      s = pending_segs.pop_back();
      s.last = 1'b1;
      pending_segs.push_back(s);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle, msg);
  endtask

  always @(posedge clk) begin : monitor
    lcdseq_pkg::seg_t want;
    row_t             sent;
    if (!rst) begin
      cycle++;
      if (seg_valid && !seg_stall) begin
        if (pending_segs.size() == 0) begin
          report_mismatch($sformatf("segment %h with none expected", seg));
        end else begin
          want = pending_segs.pop_front();
          if (seg.reg_select !== want.reg_select)
            report_mismatch($sformatf("reg_select %b, want %b", seg.reg_select, want.reg_select));
          if (seg.enable !== want.enable)
            report_mismatch($sformatf("enable %b, want %b", seg.enable, want.enable));
          if (seg.nibble !== want.nibble)
            report_mismatch($sformatf("nibble %h, want %h", seg.nibble, want.nibble));
          if (seg.hold_ms !== want.hold_ms)
            report_mismatch($sformatf("hold_ms %0d, want %0d", seg.hold_ms, want.hold_ms));
          if (seg.last !== want.last)
            report_mismatch($sformatf("last %b, want %b", seg.last, want.last));
        end
      end
      if (req_valid && !req_stall) begin
        sent = sent_rows.pop_front();
        if (sent.typed) begin
          for (int i = 0; i < 4; i++) pending_segs.push_back(sent.exp[i]);
        end else begin
          predict_segments(req);
        end
      end
      if ((seg_valid && !seg_stall) || (req_valid && !req_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("char_lcd_nibble_sequencer verification failed");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    seg_stall <= !rst && !steady && ($urandom_range(0, 99) < 24);
  end

  task automatic send_request(input row_t row);
    if (!steady) begin
      while ($urandom_range(0, 99) < 24) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    sent_rows.push_back(row);
    req_valid <= 1'b1;
    req       <= row.rq;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  initial begin : stimulus
    row_t row;
    int   counted;
    int   roll;
    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    seg_stall    = 1'b0;
    mismatches   = 0;
    cycle        = 0;
    stuck_cycles = 0;
    steady       = 1'b0;
    counted      = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) send_request(dir_tab[i]);

    while (counted < RANDOM_REQUESTS) begin
      roll = $urandom_range(0, 99);
      row  = '0;
      if (roll < 4) begin
        row.rq.cmd = lcdseq_pkg::CMD_INIT;
      end else if (roll < 9) begin
        row.rq.cmd = 3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      end else begin
        row.rq.cmd = 3'($urandom_range(lcdseq_pkg::CMD_INSTR, lcdseq_pkg::CMD_CLEAR));
      end
      row.rq.value  = 8'($urandom);
      row.rq.column = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 39));
      row.rq.row    = 1'($urandom);
      // A stretch in the middle runs with neither side holding back.
      steady = (counted >= 90) && (counted < 150);
      send_request(row);
      if (row.rq.cmd <= lcdseq_pkg::CMD_CLEAR) counted++;
    end
    steady = 1'b0;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_segs.size() == 0) begin
      $display("char_lcd_nibble_sequencer verification clean");
    end else begin
      $display("char_lcd_nibble_sequencer verification failed");
    end
    $finish;
  end

endmodule
